[rtl/mchw_pkg.sv]
// types, constants and codes for the multi-core heartbeat watchdog
// used by multi_core_heartbeat_watchdog and its testbench; no dependencies
`timescale 1ns / 1ps

package mchw_pkg;

	localparam int unsigned NUM_CORES = 4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [3:0]  STALL_MAX = 4'hF;
	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	localparam logic [2:0] CFG_DSP_COUNT      = 3'd0;
	localparam logic [2:0] CFG_RECOVERY_LIMIT = 3'd1;
	localparam logic [2:0] CFG_MON_HB_EN      = 3'd2;
	localparam logic [2:0] CFG_MON_CNT_EN     = 3'd3;
	localparam logic [2:0] CFG_DUMP_EN        = 3'd4;
	localparam logic [2:0] CFG_DUMP_LIMIT     = 3'd5;

	typedef enum logic [1:0] {
		KIND_TICK      = 2'd0,
		KIND_TURN_ON   = 2'd1,
		KIND_TURN_OFF  = 2'd2,
		KIND_BOOT_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CORE_OFF = 2'd0,
		CORE_ON  = 2'd1,
		CORE_RUN = 2'd2
	} core_state_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_INDEX  = 2'd1,
		STATUS_ALREADY_ON = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  dsp_index;
		logic [31:0] beat0;
		logic [31:0] beat1;
		logic [31:0] beat2;
		logic [31:0] beat3;
		logic [31:0] global_count;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  nudge_mask;
		logic [3:0]  dead_mask;
		logic        reset_request;
		logic        dump_request;
		logic [1:0]  dump_target;
		logic        first_reset;
		logic [15:0] reset_total;
		logic        counter_stalled;
	} rsp_t;

endpackage

[rtl/multi_core_heartbeat_watchdog.sv]
// Each beat passes through the input register and leaves through the result register,
// so one beat is accepted per clock while the receiver does not stall the result register;
// the core state, heartbeat samples, stall counts and reset total are updated as the beat
// moves from the input register to the result register, so the next beat sees them.
// Ticks check every running, present core in parallel: an unmoved heartbeat raises a
// stall count, below recovery_limit the core is nudged, at or above it the core is dead and a
// reset of all cores is requested, with a dump of the highest dead core when dump_en is set
// and the reset total is within dump_limit. Configuration writes take effect at once and must be
// made only while no beat is in flight.
// depends on mchw_pkg
`timescale 1ns / 1ps

module multi_core_heartbeat_watchdog
	import mchw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	// configuration
	logic [2:0]  dsp_count_q;
	logic [3:0]  recovery_limit_q;
	logic        mon_hb_en_q;
	logic        mon_cnt_en_q;
	logic        dump_en_q;
	logic [15:0] dump_limit_q;

	// watchdog state
	core_state_t run_state_q [NUM_CORES];
	core_state_t run_state_d [NUM_CORES];
	logic [31:0] last_beat_q [NUM_CORES];
	logic [31:0] last_beat_d [NUM_CORES];
	logic [3:0]  stall_q     [NUM_CORES];
	logic [3:0]  stall_d     [NUM_CORES];
	logic [15:0] tally_q;
	logic [15:0] tally_d;
	logic [31:0] last_global_q;
	logic [31:0] last_global_d;

	// pipeline
	logic        valid_s1;
	req_t        req_s1;
	logic        valid_s2;
	rsp_t        rsp_s2;
	rsp_t        rsp_d;
	logic        adv_s2;
	logic        fire_s1;

	logic [31:0] beats [4];
	logic [2:0]  present_n;
	logic [3:0]  present;
	logic [3:0]  stall_inc [NUM_CORES];

	assign adv_s2    = !valid_s2 || rsp_ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req_ready = !valid_s1 || adv_s2;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	assign beats[0] = req_s1.beat0;
	assign beats[1] = req_s1.beat1;
	assign beats[2] = req_s1.beat2;
	assign beats[3] = req_s1.beat3;

	assign present_n = (dsp_count_q > 3'(NUM_CORES)) ? 3'(NUM_CORES) : dsp_count_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			present[i] = (3'(i) < present_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsp_count_q      <= 3'd4;
			recovery_limit_q <= 4'd3;
			mon_hb_en_q      <= 1'b1;
			mon_cnt_en_q     <= 1'b1;
			dump_en_q        <= 1'b1;
			dump_limit_q     <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DSP_COUNT:      dsp_count_q      <= cfg_wdata[2:0];
				CFG_RECOVERY_LIMIT: recovery_limit_q <= cfg_wdata[3:0];
				CFG_MON_HB_EN:      mon_hb_en_q      <= cfg_wdata[0];
				CFG_MON_CNT_EN:     mon_cnt_en_q     <= cfg_wdata[0];
				CFG_DUMP_EN:        dump_en_q        <= cfg_wdata[0];
				CFG_DUMP_LIMIT:     dump_limit_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CORES; i++) begin
			stall_inc[i] = (stall_q[i] == STALL_MAX) ? STALL_MAX : stall_q[i] + 4'd1;
		end
	end

	always_comb begin
		run_state_d   = run_state_q;
		last_beat_d   = last_beat_q;
		stall_d       = stall_q;
		tally_d       = tally_q;
		last_global_d = last_global_q;
		rsp_d         = '0;
		rsp_d.status  = STATUS_OK;

		case (req_s1.kind)
			KIND_TICK: begin
				if (mon_hb_en_q) begin
					for (int i = 0; i < NUM_CORES; i++) begin
						if (present[i] && run_state_q[i] == CORE_RUN) begin
							if (beats[i] == last_beat_q[i]) begin
								stall_d[i] = stall_inc[i];
								if (stall_inc[i] < recovery_limit_q) begin
									rsp_d.nudge_mask[i] = 1'b1;
								end else begin
									rsp_d.dead_mask[i] = 1'b1;
									rsp_d.dump_target  = 2'(i);
								end
							end else begin
								stall_d[i] = 4'd0;
							end
							last_beat_d[i] = beats[i];
						end
					end
					if (rsp_d.dead_mask != 4'd0) begin
						rsp_d.reset_request = 1'b1;
						tally_d = (tally_q == TALLY_MAX) ? TALLY_MAX : tally_q + 16'd1;
						rsp_d.dump_request = dump_en_q && (tally_d <= dump_limit_q);
						rsp_d.first_reset  = (tally_d == 16'd1);
						for (int i = 0; i < NUM_CORES; i++) begin
							stall_d[i] = 4'd0;
							if (present[i] && run_state_q[i] != CORE_OFF) begin
								run_state_d[i] = CORE_ON;
							end
						end
					end
				end
				if (mon_cnt_en_q) begin
					rsp_d.counter_stalled = (req_s1.global_count == last_global_q);
					last_global_d         = req_s1.global_count;
				end
			end
			KIND_TURN_ON: begin
				if ({1'b0, req_s1.dsp_index} >= present_n) begin
					rsp_d.status = STATUS_BAD_INDEX;
				end else if (run_state_q[req_s1.dsp_index] != CORE_OFF) begin
					rsp_d.status = STATUS_ALREADY_ON;
				end else begin
					run_state_d[req_s1.dsp_index] = CORE_ON;
				end
			end
			KIND_TURN_OFF: begin
				if ({1'b0, req_s1.dsp_index} >= present_n) begin
					rsp_d.status = STATUS_BAD_INDEX;
				end else begin
					run_state_d[req_s1.dsp_index] = CORE_OFF;
				end
			end
			default: begin
				for (int i = 0; i < NUM_CORES; i++) begin
					if (present[i] && run_state_q[i] == CORE_ON) begin
						run_state_d[i] = CORE_RUN;
					end
				end
			end
		endcase

		rsp_d.reset_total = tally_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				run_state_q[i] <= CORE_ON;
				last_beat_q[i] <= '0;
				stall_q[i]     <= '0;
			end
			tally_q       <= '0;
			last_global_q <= '0;
		end else if (fire_s1) begin
			run_state_q   <= run_state_d;
			last_beat_q   <= last_beat_d;
			stall_q       <= stall_d;
			tally_q       <= tally_d;
			last_global_q <= last_global_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> valid_s2)
		else $error("accepted beat produced no result");

	a_dead_needs_reset: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (rsp_s2.dead_mask != 4'd0) |->
			rsp_s2.reset_request && !rsp_s2.nudge_mask[rsp_s2.dump_target])
		else $error("dead core without reset request");

	a_first_reset_total: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.first_reset |-> rsp_s2.reset_total == 16'd1)
		else $error("first reset with wrong total");

	a_tally_follows_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && rsp_d.reset_request |=> tally_q != 16'd0 && stall_q[0] == 4'd0)
		else $error("reset did not update tally or stall counts");
`endif

endmodule

[verif/multi_core_heartbeat_watchdog_tb.sv]
// self-checking testbench for multi_core_heartbeat_watchdog: directed and random
// beats with bursty sender and stalling receiver, checked against an in-bench predictor
// depends on mchw_pkg and multi_core_heartbeat_watchdog
`timescale 1ns / 1ps

module multi_core_heartbeat_watchdog_tb;
	import mchw_pkg::*;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned STORM_ROUNDS = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;

	multi_core_heartbeat_watchdog dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// register mirror
	logic [2:0]  cores_cfg = 3'd4;
	logic [3:0]  limit_cfg = 4'd3;
	logic        hb_en = 1'b1;
	logic        cnt_en = 1'b1;
	logic        dump_en = 1'b1;
	logic [15:0] dump_lim = 16'd1;

	// watchdog state mirror
	core_state_t core_state [NUM_CORES];
	logic [31:0] hb_seen [NUM_CORES];
	logic [3:0]  stall_cnt [NUM_CORES];
	logic [15:0] tally = '0;
	logic [31:0] gc_seen = '0;

	req_t pending_req [$];
	rsp_t expected_rsp [$];

	// stimulus generator state
	logic [31:0] gen_beat [NUM_CORES];
	logic [31:0] gen_gc = '0;
	int unsigned stall_pct [NUM_CORES];

	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	int unsigned ready_mode = 0;
	int unsigned ready_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic note_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		if (fail_count < 40)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic predict_item(input req_t r, output rsp_t e);
		logic [31:0] beats [NUM_CORES];
		int unsigned n;
		e = '0;
		e.status = STATUS_OK;
		n = (cores_cfg > NUM_CORES) ? NUM_CORES : int'(cores_cfg);
		beats[0] = r.beat0;
		beats[1] = r.beat1;
		beats[2] = r.beat2;
		beats[3] = r.beat3;
		case (r.kind)
			KIND_TICK: begin
				if (hb_en) begin
					for (int i = 0; i < n; i++) begin
						if (core_state[i] == CORE_RUN) begin
							if (beats[i] == hb_seen[i]) begin
								if (stall_cnt[i] != STALL_MAX)
									stall_cnt[i] = stall_cnt[i] + 4'd1;
								if (stall_cnt[i] < limit_cfg) begin
									e.nudge_mask[i] = 1'b1;
								end else begin
									e.dead_mask[i] = 1'b1;
									e.dump_target = 2'(i);
								end
							end else begin
								stall_cnt[i] = '0;
							end
							hb_seen[i] = beats[i];
						end
					end
					if (e.dead_mask != '0) begin
						e.reset_request = 1'b1;
						if (tally != TALLY_MAX)
							tally = tally + 16'd1;
						e.dump_request = dump_en && (tally <= dump_lim);
						e.first_reset = (tally == 16'd1);
						for (int i = 0; i < NUM_CORES; i++)
							stall_cnt[i] = '0;
						for (int i = 0; i < n; i++)
							if (core_state[i] != CORE_OFF)
								core_state[i] = CORE_ON;
					end
				end
				if (cnt_en) begin
					e.counter_stalled = (r.global_count == gc_seen);
					gc_seen = r.global_count;
				end
			end
			KIND_TURN_ON: begin
				if (r.dsp_index >= n)
					e.status = STATUS_BAD_INDEX;
				else if (core_state[r.dsp_index] != CORE_OFF)
					e.status = STATUS_ALREADY_ON;
				else
					core_state[r.dsp_index] = CORE_ON;
			end
			KIND_TURN_OFF: begin
				if (r.dsp_index >= n)
					e.status = STATUS_BAD_INDEX;
				else
					core_state[r.dsp_index] = CORE_OFF;
			end
			default: begin
				for (int i = 0; i < n; i++)
					if (core_state[i] == CORE_ON)
						core_state[i] = CORE_RUN;
			end
		endcase
		e.reset_total = tally;
	endtask

	task automatic push_item(input kind_t k, input logic [1:0] idx, input logic [31:0] b0,
		input logic [31:0] b1, input logic [31:0] b2, input logic [31:0] b3,
		input logic [31:0] gc);
		req_t r;
		r.kind = k;
		r.dsp_index = idx;
		r.beat0 = b0;
		r.beat1 = b1;
		r.beat2 = b2;
		r.beat3 = b3;
		r.global_count = gc;
		pending_req.push_back(r);
	endtask

	task automatic push_random();
		int unsigned pick;
		logic [1:0] idx;
		pick = $urandom_range(0, 99);
		idx = 2'($urandom_range(0, 3));
		if (pick < 62) begin
			for (int i = 0; i < NUM_CORES; i++)
				if ($urandom_range(0, 99) >= stall_pct[i])
					gen_beat[i] = ($urandom_range(0, 3) == 0) ? $urandom() : gen_beat[i] + 32'd1;
			if ($urandom_range(0, 9) >= 3)
				gen_gc = gen_gc + $urandom_range(1, 1000);
			push_item(KIND_TICK, idx, gen_beat[0], gen_beat[1], gen_beat[2], gen_beat[3],
				gen_gc);
		end else if (pick < 74) begin
			push_item(KIND_BOOT_DONE, idx, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom());
		end else if (pick < 83) begin
			push_item(KIND_TURN_ON, idx, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom());
		end else if (pick < 90) begin
			push_item(KIND_TURN_OFF, idx, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom());
		end else begin
			// noise tick
			push_item(KIND_TICK, idx, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom());
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_DSP_COUNT:      cores_cfg = val[2:0];
			CFG_RECOVERY_LIMIT: limit_cfg = val[3:0];
			CFG_MON_HB_EN:      hb_en = val[0];
			CFG_MON_CNT_EN:     cnt_en = val[0];
			CFG_DUMP_EN:        dump_en = val[0];
			CFG_DUMP_LIMIT:     dump_lim = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [15:0] cores, input logic [15:0] lim,
		input logic [15:0] hb, input logic [15:0] cnt, input logic [15:0] dmp,
		input logic [15:0] dlim);
		cfg_write(CFG_DSP_COUNT, cores);
		cfg_write(CFG_RECOVERY_LIMIT, lim);
		cfg_write(CFG_MON_HB_EN, hb);
		cfg_write(CFG_MON_CNT_EN, cnt);
		cfg_write(CFG_DUMP_EN, dmp);
		cfg_write(CFG_DUMP_LIMIT, dlim);
	endtask

	task automatic run_phase(input int unsigned count);
		@(negedge clk);
		for (int i = 0; i < NUM_CORES; i++)
			stall_pct[i] = ($urandom_range(0, 3) == 0) ? 95 : $urandom_range(10, 60);
		repeat (count) push_random();
		wait_drained();
	endtask

	// sender: bursts of beats with random gaps
	always @(posedge clk) begin : drive
		rsp_t want;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				predict_item(req, want);
				expected_rsp.push_back(want);
			end
			if (!req_valid || req_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_req.size() != 0) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: always ready, coin flip, or mostly stalled, in randomly chosen modes
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_left <= $urandom_range(16, 96);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				note_mismatch("result with nothing expected", rsp.reset_total, 0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", rsp.status, want.status);
				if (rsp.nudge_mask !== want.nudge_mask)
					note_mismatch("nudge_mask", rsp.nudge_mask, want.nudge_mask);
				if (rsp.dead_mask !== want.dead_mask)
					note_mismatch("dead_mask", rsp.dead_mask, want.dead_mask);
				if (rsp.reset_request !== want.reset_request)
					note_mismatch("reset_request", rsp.reset_request, want.reset_request);
				if (rsp.dump_request !== want.dump_request)
					note_mismatch("dump_request", rsp.dump_request, want.dump_request);
				if (rsp.dump_target !== want.dump_target)
					note_mismatch("dump_target", rsp.dump_target, want.dump_target);
				if (rsp.first_reset !== want.first_reset)
					note_mismatch("first_reset", rsp.first_reset, want.first_reset);
				if (rsp.reset_total !== want.reset_total)
					note_mismatch("reset_total", rsp.reset_total, want.reset_total);
				if (rsp.counter_stalled !== want.counter_stalled)
					note_mismatch("counter_stalled", rsp.counter_stalled, want.counter_stalled);
			end
		end
	end

	// ends the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < NUM_CORES; i++) begin
			core_state[i] = CORE_ON;
			hb_seen[i] = '0;
			stall_cnt[i] = '0;
			gen_beat[i] = '0;
			stall_pct[i] = 40;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, four cores, limit of three
		push_item(KIND_TICK, 2'd0, '0, '0, '0, '0, '0);
		push_item(KIND_TURN_ON, 2'd0, '0, '0, '0, '0, '0);
		push_item(KIND_TURN_OFF, 2'd3, '0, '0, '0, '0, '0);
		push_item(KIND_TURN_OFF, 2'd3, '0, '0, '0, '0, '0);
		push_item(KIND_BOOT_DONE, 2'd0, '0, '0, '0, '0, '0);
		push_item(KIND_TURN_ON, 2'd3, '0, '0, '0, '0, '0);
		push_item(KIND_TICK, 2'd3, '1, '1, '1, '1, '1);
		push_item(KIND_BOOT_DONE, 2'd0, '1, '1, '1, '1, '1);
		push_item(KIND_TICK, 2'd0, '1, 32'd1, 32'd2, '0, '1);
		push_item(KIND_TICK, 2'd0, '1, 32'd1, 32'd3, '0, 32'd7);
		push_item(KIND_TICK, 2'd0, '1, 32'd1, 32'd3, '0, 32'd8);
		push_item(KIND_TICK, 2'd0, '1, 32'd1, 32'd3, '0, 32'd9);
		push_item(KIND_TURN_OFF, 2'd1, '0, '0, '0, '0, '0);
		push_item(KIND_BOOT_DONE, 2'd2, '0, '0, '0, '0, '0);
		repeat (3) push_item(KIND_TICK, 2'd1, 32'h8000_0000, 32'd5, 32'h7FFF_FFFF, 32'd6,
			32'd10);
		push_item(KIND_TURN_ON, 2'd1, '0, '0, '0, '0, '0);
		push_item(KIND_BOOT_DONE, 2'd3, '0, '0, '0, '0, '0);
		push_item(KIND_TICK, 2'd2, 32'd1, 32'd2, 32'd3, 32'd4, '0);
		wait_drained();

		apply_setting(16'd4, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
		run_phase(200);
		apply_setting(16'd4, 16'd15, 16'd1, 16'd1, 16'd1, 16'd0);
		run_phase(220);
		apply_setting(16'd2, 16'd3, 16'd1, 16'd0, 16'd0, 16'd5);
		run_phase(200);
		apply_setting(16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd3);
		run_phase(200);
		// no core present: every index is invalid
		apply_setting(16'd0, 16'd2, 16'd1, 16'd1, 16'd1, 16'd1);
		run_phase(60);
		apply_setting(16'd7, 16'd2, 16'd0, 16'd1, 16'd1, 16'd100);
		run_phase(150);
		apply_setting(16'd3, 16'd4, 16'd1, 16'd1, 16'd0, 16'd20);
		run_phase(200);
		repeat (3) begin
			apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()), 16'($urandom()));
			run_phase(150);
		end

		// a storm of resets with one core dying every other beat
		apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
		@(negedge clk);
		push_item(KIND_TURN_ON, 2'd0, '0, '0, '0, '0, '0);
		repeat (STORM_ROUNDS) begin
			push_item(KIND_BOOT_DONE, 2'd0, '0, '0, '0, '0, '0);
			push_item(KIND_TICK, 2'd0, 32'h5A5A_5A5A, '0, '0, '0, $urandom());
		end
		wait_drained();

		apply_setting(16'd4, 16'd2, 16'd1, 16'd1, 16'd1, 16'hFFFE);
		run_phase(120);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
